// ===== rtl/core/hcw_pkg.sv =====
// Shared types, constants and functions of the HSV colour wheel pixel generator.
`default_nettype none
package hcw_pkg;

    localparam int DISC_RADIUS  = 128;
    localparam int RADIUS_SQ    = DISC_RADIUS * DISC_RADIUS;
    localparam int CORDIC_STEPS = 15;
    localparam int N_CELLS      = 16;
    localparam int STAGE_W      = 4;
    localparam int POST_STAGES  = 4;
    localparam int PIPE_DEPTH   = 1 + N_CELLS + POST_STAGES;

    localparam logic [14:0] QUARTER_TURN = 15'd16384;
    localparam logic [15:0] HALF_TURN    = 16'd32768;

    // Register map (index = byte address / 4).
    localparam logic ADDR_LEVEL = 1'b0;
    localparam logic [7:0] LEVEL_RESET = 8'd255;

    typedef struct packed {
        logic                valid;
        logic                in_disc;
        logic                dx_neg;
        logic                dy_neg;
        logic                ax_zero;
        logic                ay_zero;
        logic signed [26:0]  x;
        logic signed [26:0]  y;
        logic signed [16:0]  z;
        logic [15:0]         d2;
        logic [17:0]         rem;
        logic [15:0]         root;
        logic [15:0]         idx;
    } t_cell_data;

    // Arctangent of 2^-i in units of 1/65536 of a turn.
    function automatic logic signed [16:0] atan_unit(input logic [STAGE_W-1:0] i);
        logic signed [16:0] r;
        case (i)
            4'd0:    r = 17'sd8192;
            4'd1:    r = 17'sd4836;
            4'd2:    r = 17'sd2555;
            4'd3:    r = 17'sd1297;
            4'd4:    r = 17'sd651;
            4'd5:    r = 17'sd326;
            4'd6:    r = 17'sd163;
            4'd7:    r = 17'sd81;
            4'd8:    r = 17'sd41;
            4'd9:    r = 17'sd20;
            4'd10:   r = 17'sd10;
            4'd11:   r = 17'sd5;
            4'd12:   r = 17'sd3;
            4'd13:   r = 17'sd1;
            4'd14:   r = 17'sd1;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hsv_color_wheel_pixel_top.sv =====
// Top level of the HSV colour wheel pixel generator: register port, input stage, cells, colour stages.
//
// Each transaction takes a pixel (column, row) of a 256 by 256 image and returns its colour on
// an HSV colour wheel centred on pixel (128, 128), together with its pixel index. A new
// transaction is taken in every clock cycle: busy is never raised, and each result appears on
// the o_ ports for exactly one cycle, flagged by o_done. A transaction passes through one input
// register, the chain of sixteen cells, each of which produces one bit of the radius square
// root and all but the last of which also perform one CORDIC step of the hue angle, and four
// conversion stages. The receiver cannot hold results off, so it must take every result
// in the cycle that it is shown. The HSV value comes from the level register (byte address 0,
// reset 255); it should only be written while no transactions are in flight.
`default_nettype none
module hsv_color_wheel_pixel_top
    import hcw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Command channel.
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_col,
    input  wire logic [7:0]  i_row,
    // Result channel.
    output logic             o_done,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [15:0]      o_pixel_index,
    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // The pipeline never stalls, so the block is never busy.
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Level register. Only address bit 2 selects a register; other words are ignored.
    logic [7:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_LEVEL)) begin
            r_level <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_LEVEL) ? {24'd0, r_level} : 32'd0;

    // Input stage: offsets from the centre, squared distance and the start vector of the
    // CORDIC, which works on the magnitudes in the first quadrant.
    logic signed [8:0]  dx, dy;
    logic [8:0]         ax, ay;
    logic signed [17:0] d2_full;
    t_cell_data         n_in;
    t_cell_data         r_in;

    always_comb begin
        dx      = $signed({1'b0, i_col}) - 9'sd128;
        dy      = 9'sd128 - $signed({1'b0, i_row});
        ax      = dx[8] ? 9'(-dx) : 9'(dx);
        ay      = dy[8] ? 9'(-dy) : 9'(dy);
        d2_full = 18'(dx) * 18'(dx) + 18'(dy) * 18'(dy);

        n_in         = '0;
        n_in.valid   = start && !busy && i_rst_n;
        n_in.in_disc = (d2_full <= 18'(RADIUS_SQ));
        n_in.dx_neg  = dx[8];
        n_in.dy_neg  = dy[8];
        n_in.ax_zero = (ax == 9'd0);
        n_in.ay_zero = (ay == 9'd0);
        n_in.x       = $signed({2'b00, ax, 16'd0});
        n_in.y       = $signed({2'b00, ay, 16'd0});
        n_in.d2      = d2_full[15:0];
        n_in.idx     = {i_row, i_col};
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
    end

    // The chain of cells: one root bit each and one rotation in all but the last, handed on every cycle.
    t_cell_data w_chain [0:N_CELLS];

    assign w_chain[0] = r_in;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        hcw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_W'(g)),
            .i_data  (w_chain[g]),
            .o_data  (w_chain[g+1])
        );
    end

    hcw_color u_color (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_level       (r_level),
        .i_data        (w_chain[N_CELLS]),
        .o_done        (o_done),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_pixel_index (o_pixel_index)
    );

endmodule
`default_nettype wire

// ===== rtl/core/hcw_cell.sv =====
// One chain cell: a root bit of the radius square root and, below stage 15, a CORDIC step.
`default_nettype none
module hcw_cell
    import hcw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [STAGE_W-1:0] i_stage,
    input  wire t_cell_data         i_data,
    output t_cell_data              o_data
);

    t_cell_data          r_data;
    t_cell_data          n_data;
    logic signed [26:0]  xs;
    logic signed [26:0]  ys;
    logic [31:0]         radicand;
    logic [1:0]          pair;
    logic [17:0]         rem_sh;
    logic [17:0]         trial;

    always_comb begin
        n_data   = i_data;
        xs       = i_data.x >>> i_stage;
        ys       = i_data.y >>> i_stage;
        radicand = {i_data.d2, 16'd0};
        pair     = radicand[(5'd30 - {i_stage, 1'b0}) +: 2];
        rem_sh   = {i_data.rem[15:0], pair};
        trial    = {i_data.root, 2'b01};

        if (32'(i_stage) < CORDIC_STEPS) begin
            if (!i_data.y[26]) begin
                n_data.x = i_data.x + ys;
                n_data.y = i_data.y - xs;
                n_data.z = i_data.z + atan_unit(i_stage);
            end else begin
                n_data.x = i_data.x - ys;
                n_data.y = i_data.y + xs;
                n_data.z = i_data.z - atan_unit(i_stage);
            end
        end

        if (rem_sh >= trial) begin
            n_data.rem  = rem_sh - trial;
            n_data.root = {i_data.root[14:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh;
            n_data.root = {i_data.root[14:0], 1'b0};
        end

        if (!i_rst_n) begin
            n_data.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

// ===== rtl/core/hcw_color.sv =====
// Hue and saturation to RGB conversion stages at the end of the cell chain.
`default_nettype none
module hcw_color
    import hcw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_level,
    input  wire t_cell_data  i_data,
    output logic             o_done,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [15:0]      o_pixel_index
);

    // Stage A: angle, sector, fraction and saturation.
    logic [14:0] quad;
    logic [15:0] angle;
    logic [18:0] h6;
    logic [8:0]  sat;
    logic        r_a_valid, r_a_inside;
    logic [2:0]  r_a_sector;
    logic [7:0]  r_a_frac;
    logic [8:0]  r_a_sat;
    logic [15:0] r_a_idx;

    always_comb begin
        if (i_data.ay_zero) begin
            quad = 15'd0;
        end else if (i_data.ax_zero) begin
            quad = QUARTER_TURN;
        end else if (i_data.z[16]) begin
            quad = 15'd0;
        end else if (i_data.z > 17'(QUARTER_TURN)) begin
            quad = QUARTER_TURN;
        end else begin
            quad = i_data.z[14:0];
        end
        case ({i_data.dx_neg, i_data.dy_neg})
            2'b00:   angle = {1'b0, quad};
            2'b10:   angle = HALF_TURN - {1'b0, quad};
            2'b11:   angle = HALF_TURN + {1'b0, quad};
            default: angle = 16'd0 - {1'b0, quad};
        endcase
        h6 = 19'(angle) * 19'd6;
        if (i_data.root[15:7] > 9'd256) begin
            sat = 9'd256;
        end else begin
            sat = i_data.root[15:7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_data.valid;
        end
        r_a_inside <= i_data.in_disc;
        r_a_sector <= h6[18:16];
        r_a_frac   <= h6[15:8];
        r_a_sat    <= sat;
        r_a_idx    <= i_data.idx;
    end

    // Stage B: the factors (1 - s), (1 - s*f) and (1 - s*(1 - f)).
    logic [16:0] sf;
    logic [17:0] sg;
    logic        r_b_valid, r_b_inside;
    logic [2:0]  r_b_sector;
    logic [8:0]  r_b_pm;
    logic [16:0] r_b_qm, r_b_tm;
    logic [15:0] r_b_idx;

    always_comb begin
        sf = 17'(r_a_sat) * 17'(r_a_frac);
        sg = 18'(r_a_sat) * (18'd256 - 18'(r_a_frac));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_inside <= r_a_inside;
        r_b_sector <= r_a_sector;
        r_b_pm     <= 9'd256 - r_a_sat;
        r_b_qm     <= 17'h10000 - sf;
        r_b_tm     <= 17'(18'h10000 - sg);
        r_b_idx    <= r_a_idx;
    end

    // Stage C: scale by the value register.
    logic [16:0] pp;
    logic [24:0] qp, tp;
    logic        r_c_valid, r_c_inside;
    logic [2:0]  r_c_sector;
    logic [7:0]  r_c_v, r_c_p, r_c_q, r_c_t;
    logic [15:0] r_c_idx;

    always_comb begin
        pp = 17'(i_level) * 17'(r_b_pm);
        qp = 25'(i_level) * 25'(r_b_qm);
        tp = 25'(i_level) * 25'(r_b_tm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_inside <= r_b_inside;
        r_c_sector <= r_b_sector;
        r_c_v      <= i_level;
        r_c_p      <= pp[15:8];
        r_c_q      <= qp[23:16];
        r_c_t      <= tp[23:16];
        r_c_idx    <= r_b_idx;
    end

    // Stage D: sector select, black outside the disc, and output register.
    logic [7:0] n_red, n_green, n_blue;

    always_comb begin
        case (r_c_sector)
            3'd0:    begin n_red = r_c_v; n_green = r_c_t; n_blue = r_c_p; end
            3'd1:    begin n_red = r_c_q; n_green = r_c_v; n_blue = r_c_p; end
            3'd2:    begin n_red = r_c_p; n_green = r_c_v; n_blue = r_c_t; end
            3'd3:    begin n_red = r_c_p; n_green = r_c_q; n_blue = r_c_v; end
            3'd4:    begin n_red = r_c_t; n_green = r_c_p; n_blue = r_c_v; end
            default: begin n_red = r_c_v; n_green = r_c_p; n_blue = r_c_q; end
        endcase
        if (!r_c_inside) begin
            n_red   = 8'd0;
            n_green = 8'd0;
            n_blue  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_c_valid;
        end
        o_red         <= n_red;
        o_green       <= n_green;
        o_blue        <= n_blue;
        o_alpha       <= r_c_inside ? 8'd255 : 8'd0;
        o_pixel_index <= r_c_idx;
    end

endmodule
`default_nettype wire

// ===== rtl/core/hcw_checker.sv =====
// Port-level checker for the HSV colour wheel pixel generator and its bind statement.
`default_nettype none
module hcw_checker
    import hcw_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [7:0]  i_col,
    input wire logic [7:0]  i_row,
    input wire logic        o_done,
    input wire logic [7:0]  o_red,
    input wire logic [7:0]  o_green,
    input wire logic [7:0]  o_blue,
    input wire logic [7:0]  o_alpha,
    input wire logic [15:0] o_pixel_index
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised although the pipeline cannot stall");

    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, PIPE_DEPTH))
        else $error("result without a transaction at the pipeline depth before");

    a_index_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pixel_index == {$past(i_row, PIPE_DEPTH), $past(i_col, PIPE_DEPTH)}))
        else $error("pixel index does not match the coordinate of its transaction");

    a_alpha_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_alpha == 8'd0) || (o_alpha == 8'd255)))
        else $error("alpha is neither transparent nor opaque");

    a_outside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_alpha == 8'd0)) |-> ((o_red | o_green | o_blue) == 8'd0))
        else $error("colour present outside the disc");

endmodule

bind hsv_color_wheel_pixel_top hcw_checker u_hcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_col         (i_col),
    .i_row         (i_row),
    .o_done        (o_done),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_alpha       (o_alpha),
    .o_pixel_index (o_pixel_index)
);
`default_nettype wire
